@@ design/bpc_pkg.sv @@
// bpc_pkg: shared types and constants of the button press classifier
// holds the event codes, register indexes, reset values and the config bundle
// no dependencies
`default_nettype none

package bpc_pkg;

    // event codes carried on the result stream
    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_SHORT  = 3'd1;
    localparam logic [2:0] EV_DOUBLE = 3'd2;
    localparam logic [2:0] EV_LONG   = 3'd3;
    localparam logic [2:0] EV_OTA    = 3'd4;
    localparam logic [2:0] EV_VLONG  = 3'd5;

    // register indexes on the config port
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_HOLD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OTA_HOLD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VLONG_HOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DBL_WINDOW = 3'd4;

    // reset values of the registers, in ms
    localparam logic [15:0] RST_DEBOUNCE   = 16'd50;
    localparam logic [15:0] RST_LONG_HOLD  = 16'd1000;
    localparam logic [15:0] RST_OTA_HOLD   = 16'd5000;
    localparam logic [15:0] RST_VLONG_HOLD = 16'd10000;
    localparam logic [15:0] RST_DBL_WINDOW = 16'd400;

    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 8;

    typedef struct packed {
        logic [15:0] debounce_time;
        logic [15:0] long_hold_time;
        logic [15:0] ota_hold_time;
        logic [15:0] very_long_hold_time;
        logic [15:0] double_window;
    } cfg_t;

endpackage

`default_nettype wire

@@ design/bpc_core.sv @@
// bpc_core: press classification state machine with its result register
// one tick is processed per enabled cycle; uses bpc_pkg for codes and config
`default_nettype none

module bpc_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire logic          pressed,
    input  wire logic [31:0]   now_ms,
    input  wire bpc_pkg::cfg_t cfg,
    output logic      [2:0]    event_res
);
    import bpc_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_DEBOUNCE = 3'd1,
        PH_PRESSED  = 3'd2,
        PH_LONG     = 3'd3,
        PH_OTA      = 3'd4,
        PH_VLONG    = 3'd5
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] debounce_start_reg, debounce_start_next;
    logic [31:0] press_start_reg, press_start_next;
    logic [31:0] last_release_reg, last_release_next;
    logic [2:0]  event_reg, event_next;

    logic [31:0] held;
    logic [31:0] since_debounce;
    logic [31:0] since_release;
    logic        hit_long, hit_ota, hit_vlong, debounced, in_window;

    // wrapping differences against zero-extended thresholds
    assign held           = now_ms - press_start_reg;
    assign since_debounce = now_ms - debounce_start_reg;
    assign since_release  = now_ms - last_release_reg;
    assign debounced = since_debounce >= {16'd0, cfg.debounce_time};
    assign hit_long  = held >= {16'd0, cfg.long_hold_time};
    assign hit_ota   = held >= {16'd0, cfg.ota_hold_time};
    assign hit_vlong = held >= {16'd0, cfg.very_long_hold_time};
    assign in_window = since_release < {16'd0, cfg.double_window};

    always_comb
    begin
        phase_next          = phase_reg;
        debounce_start_next = debounce_start_reg;
        press_start_next    = press_start_reg;
        last_release_next   = last_release_reg;
        event_next          = EV_NONE;
        unique case (phase_reg)
            PH_DEBOUNCE:
            begin
                if (!pressed)
                begin
                    phase_next = PH_IDLE;
                end
                else if (debounced)
                begin
                    phase_next       = PH_PRESSED;
                    press_start_next = now_ms;
                end
            end
            PH_PRESSED:
            begin
                if (!pressed)
                begin
                    phase_next = PH_IDLE;
                    if (in_window)
                    begin
                        last_release_next = 32'd0;
                        event_next        = EV_DOUBLE;
                    end
                    else
                    begin
                        last_release_next = now_ms;
                        event_next        = EV_SHORT;
                    end
                end
                else if (hit_vlong)
                begin
                    phase_next = PH_VLONG;
                    event_next = EV_VLONG;
                end
                else if (hit_ota)
                begin
                    phase_next = PH_OTA;
                    event_next = EV_OTA;
                end
                else if (hit_long)
                begin
                    phase_next = PH_LONG;
                    event_next = EV_LONG;
                end
            end
            PH_LONG:
            begin
                if (!pressed)
                begin
                    phase_next = PH_IDLE;
                end
                else if (hit_vlong)
                begin
                    phase_next = PH_VLONG;
                    event_next = EV_VLONG;
                end
                else if (hit_ota)
                begin
                    phase_next = PH_OTA;
                    event_next = EV_OTA;
                end
            end
            PH_OTA:
            begin
                if (!pressed)
                begin
                    phase_next = PH_IDLE;
                end
                else if (hit_vlong)
                begin
                    phase_next = PH_VLONG;
                    event_next = EV_VLONG;
                end
            end
            PH_VLONG:
            begin
                if (!pressed)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                // idle, and any unused code behaves as idle
                if (pressed)
                begin
                    phase_next          = PH_DEBOUNCE;
                    debounce_start_next = now_ms;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            debounce_start_reg <= 32'd0;
            press_start_reg    <= 32'd0;
            last_release_reg   <= 32'd0;
            event_reg          <= EV_NONE;
        end
        else if (step)
        begin
            phase_reg          <= phase_next;
            debounce_start_reg <= debounce_start_next;
            press_start_reg    <= press_start_next;
            last_release_reg   <= last_release_next;
            event_reg          <= event_next;
        end
    end

    assign event_res = event_reg;

endmodule

`default_nettype wire

@@ design/button_press_classifier_unit.sv @@
// button_press_classifier_unit: top level of the button press classifier
// holds the config registers, the input word register and the stream control
// depends on bpc_pkg and bpc_core
//
//   channel   direction  handshake           payload
//   s_*       in         s_tvalid/s_tready   s_tdata: pressed, now_ms
//   m_*       out        m_tvalid/m_tready   m_tdata: event_res
//   cfg_*     in         cfg_we              cfg_index, cfg_wdata
//
// one poll tick per cycle sustained while m_* does not stall; an accepted word
// passes through the input register and then leaves from the result register
// the state machine step, its wrapping time differences and its five threshold
// compares are the only logic between input register and result register
// reset (rst_n low, asynchronous) empties both stages, returns to idle and
// loads the default timings
// a stall on m_* holds the result; s_tready only drops when both stages are full
`default_nettype none

module button_press_classifier_unit (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // slave side: [0] pressed, [32:1] now_ms, [39:33] zero
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [bpc_pkg::IN_TDATA_W-1:0]        s_tdata,
    // master side: [2:0] event_res, [7:3] zero
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic      [bpc_pkg::OUT_TDATA_W-1:0]       m_tdata,
    // config write port
    input  wire logic                                  cfg_we,
    input  wire logic [bpc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [15:0]                           cfg_wdata
);
    import bpc_pkg::*;

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    logic        in_pressed_reg;
    logic [31:0] in_now_reg;
    logic        out_valid_reg;
    logic        step;
    logic [2:0]  event_res;

    // the input word moves on when the result slot is empty or being drained
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    // config registers, out-of-range indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_time       <= RST_DEBOUNCE;
            cfg_reg.long_hold_time      <= RST_LONG_HOLD;
            cfg_reg.ota_hold_time       <= RST_OTA_HOLD;
            cfg_reg.very_long_hold_time <= RST_VLONG_HOLD;
            cfg_reg.double_window       <= RST_DBL_WINDOW;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE:   cfg_reg.debounce_time       <= cfg_wdata;
                REG_LONG_HOLD:  cfg_reg.long_hold_time      <= cfg_wdata;
                REG_OTA_HOLD:   cfg_reg.ota_hold_time       <= cfg_wdata;
                REG_VLONG_HOLD: cfg_reg.very_long_hold_time <= cfg_wdata;
                REG_DBL_WINDOW: cfg_reg.double_window       <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // input stage valid and result stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                in_valid_reg <= 1'b0;
            end

            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // input payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_pressed_reg <= s_tdata[0];
            in_now_reg     <= s_tdata[32:1];
        end
    end

    bpc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .pressed   (in_pressed_reg),
        .now_ms    (in_now_reg),
        .cfg       (cfg_reg),
        .event_res (event_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-3){1'b0}}, event_res};

endmodule

`default_nettype wire

@@ design/bpc_checker.sv @@
// bpc_checker: port-level assertions for the button press classifier
// bound to button_press_classifier_unit; uses bpc_pkg event codes
`default_nettype none

module bpc_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [bpc_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import bpc_pkg::*;

    logic release_seen_reg;

    // last delivered word was a short or double press
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            release_seen_reg <= 1'b0;
        end
        else if (m_tvalid && m_tready)
        begin
            release_seen_reg <= (m_tdata[2:0] == EV_SHORT) || (m_tdata[2:0] == EV_DOUBLE);
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

    // only a stalled output may hold off the input
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |-> m_tvalid && !m_tready)
        else $error("input held off while output drains");

    // event codes stay in range with zero padding
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] <= EV_VLONG && m_tdata[7:3] == 5'd0)
        else $error("bad event code");

    // a release returns to idle, so the following tick reports nothing
    a_after_release: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && release_seen_reg |-> m_tdata[2:0] == EV_NONE)
        else $error("event straight after a release");

endmodule

bind button_press_classifier_unit bpc_checker u_bpc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ tb/sv/bpc_event_checker_pkg.sv @@
// bpc_event_checker_pkg: expected-event tracker for the button press classifier bench
// mirrors the press state machine per accepted poll word and checks each result word
// depends on bpc_pkg
package bpc_event_checker_pkg;

    import bpc_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_DEBOUNCE,
        PH_PRESSED,
        PH_LONG_FIRED,
        PH_OTA_FIRED,
        PH_VLONG_FIRED
    } btn_phase_t;

    class press_event_checker;
        cfg_t        timings;
        btn_phase_t  phase;
        logic [31:0] debounce_start;
        logic [31:0] press_start;
        logic [31:0] last_release;
        logic [2:0]  events_due[$];
        int unsigned failures;

        function new();
            timings = '{RST_DEBOUNCE, RST_LONG_HOLD, RST_OTA_HOLD, RST_VLONG_HOLD,
                        RST_DBL_WINDOW};
            phase          = PH_IDLE;
            debounce_start = '0;
            press_start    = '0;
            last_release   = '0;
            failures       = 0;
        endfunction

        function int pending();
            return events_due.size();
        endfunction

        // spare indexes fall through and change nothing
        function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
            case (idx)
                REG_DEBOUNCE:   timings.debounce_time       = val;
                REG_LONG_HOLD:  timings.long_hold_time      = val;
                REG_OTA_HOLD:   timings.ota_hold_time       = val;
                REG_VLONG_HOLD: timings.very_long_hold_time = val;
                REG_DBL_WINDOW: timings.double_window       = val;
                default:        ;
            endcase
        endfunction

        // one poll tick: advance the press state and queue the event it gives
        function void note_tick(input logic down, input logic [31:0] now_ms);
            logic [31:0] held;
            logic [31:0] since_debounce;
            logic [31:0] since_release;
            logic [2:0]  ev;
            held           = now_ms - press_start;
            since_debounce = now_ms - debounce_start;
            since_release  = now_ms - last_release;
            ev             = EV_NONE;
            case (phase)
                PH_DEBOUNCE:
                begin
                    if (!down)
                        phase = PH_IDLE;
                    else if (since_debounce >= {16'b0, timings.debounce_time})
                    begin
                        phase       = PH_PRESSED;
                        press_start = now_ms;
                    end
                end
                PH_PRESSED, PH_LONG_FIRED, PH_OTA_FIRED:
                begin
                    if (!down)
                    begin
                        if (phase == PH_PRESSED)
                        begin
                            if (since_release < {16'b0, timings.double_window})
                            begin
                                last_release = '0;
                                ev           = EV_DOUBLE;
                            end
                            else
                            begin
                                last_release = now_ms;
                                ev           = EV_SHORT;
                            end
                        end
                        phase = PH_IDLE;
                    end
                    // longest threshold first, each hold event only once
                    else if (held >= {16'b0, timings.very_long_hold_time})
                    begin
                        phase = PH_VLONG_FIRED;
                        ev    = EV_VLONG;
                    end
                    else if (held >= {16'b0, timings.ota_hold_time} && phase != PH_OTA_FIRED)
                    begin
                        phase = PH_OTA_FIRED;
                        ev    = EV_OTA;
                    end
                    else if (held >= {16'b0, timings.long_hold_time} && phase == PH_PRESSED)
                    begin
                        phase = PH_LONG_FIRED;
                        ev    = EV_LONG;
                    end
                end
                PH_VLONG_FIRED:
                begin
                    if (!down)
                        phase = PH_IDLE;
                end
                default:
                begin
                    if (down)
                    begin
                        phase          = PH_DEBOUNCE;
                        debounce_start = now_ms;
                    end
                    else
                        phase = PH_IDLE;
                end
            endcase
            events_due.push_back(ev);
        endfunction

        function void check_event(input logic [2:0] got);
            logic [2:0] want;
            if (events_due.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected result word, expected none actual event %0d",
                         $time, got);
            end
            else
            begin
                want = events_due.pop_front();
                if (got !== want)
                begin
                    failures++;
                    $display("%0t: event_res mismatch, expected %0d actual %0d",
                             $time, want, got);
                end
            end
        endfunction
    endclass

endpackage

@@ tb/sv/button_press_classifier_unit_tb.sv @@
// button_press_classifier_unit_tb: self-checking bench for the button press classifier
// drives poll words with random gaps and stalls, checks every event word in order
// depends on bpc_pkg, bpc_event_checker_pkg and button_press_classifier_unit
module button_press_classifier_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import bpc_pkg::*;
    import bpc_event_checker_pkg::*;

    // indexes past the last register, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

    localparam int unsigned RUN_LIMIT    = 400000;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned MAX_WAIT     = 17;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata;   // [0] pressed, [32:1] now_ms, [39:33] zero
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_TDATA_W-1:0]  m_tdata;   // [2:0] event_res, [7:3] zero
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [15:0]             cfg_wdata;

    press_event_checker      score_board;
    logic [31:0]             tick_ms;      // running poll time of the stimulus
    bit                      src_burst;    // sender runs back to back while set
    int unsigned             cycle_count = 0;

    button_press_classifier_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // watchdog: a hung handshake ends the run here
    initial
    begin
        wait (cycle_count >= RUN_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic cfg_t make_timings(input logic [15:0] deb, input logic [15:0] lng,
                                          input logic [15:0] ota, input logic [15:0] vlong,
                                          input logic [15:0] dbl);
        cfg_t t;
        t.debounce_time       = deb;
        t.long_hold_time      = lng;
        t.ota_hold_time       = ota;
        t.very_long_hold_time = vlong;
        t.double_window       = dbl;
        return t;
    endfunction

    // one register write per edge, cfg_we stays high between consecutive writes
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        score_board.write_reg(idx, val);
    endtask

    task automatic set_timings(input cfg_t t, input bit poke_spare);
        put_reg(REG_DEBOUNCE,   t.debounce_time);
        put_reg(REG_LONG_HOLD,  t.long_hold_time);
        put_reg(REG_OTA_HOLD,   t.ota_hold_time);
        put_reg(REG_VLONG_HOLD, t.very_long_hold_time);
        put_reg(REG_DBL_WINDOW, t.double_window);
        if (poke_spare)
        begin
            for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++)
                put_reg(CFG_IDX_W'(i), 16'($urandom));
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // offer one poll word, note it once the handshake completes
    // valid is left high so a zero gap keeps the stream back to back
    task automatic send_tick(input logic down, input logic [31:0] stamp);
        int gap;
        if ($urandom_range(0, 63) == 0)
            src_burst = !src_burst;
        gap = src_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, stamp, down};
        do
            @(posedge clk);
        while (!s_tready);
        score_board.note_tick(down, stamp);
    endtask

    // sender holds off until every event word has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (score_board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // mostly whole press/release runs with random timing, some noise and glitches
    task automatic run_presses(input int n_items, input int unsigned max_step,
                               input int unsigned max_run);
        int          sent;
        int          press_len;
        int          rel_len;
        int unsigned step_cap;
        int          kind;
        sent = 0;
        while (sent < n_items)
        begin
            kind     = $urandom_range(0, 15);
            step_cap = $urandom_range(1, max_step);
            if (kind == 0)
            begin
                // time jumps anywhere, level random
                tick_ms = $urandom;
                send_tick(1'($urandom_range(0, 1)), tick_ms);
                sent++;
            end
            else if (kind == 1)
            begin
                // bounce: press dropped on the very next tick
                tick_ms += $urandom_range(0, 1);
                send_tick(1'b1, tick_ms);
                tick_ms += $urandom_range(0, 1);
                send_tick(1'b0, tick_ms);
                sent += 2;
            end
            else
            begin
                press_len = $urandom_range(1, max_run);
                rel_len   = $urandom_range(1, 3);
                repeat (press_len)
                begin
                    tick_ms += $urandom_range(0, step_cap);
                    send_tick(1'b1, tick_ms);
                end
                repeat (rel_len)
                begin
                    tick_ms += $urandom_range(0, step_cap);
                    send_tick(1'b0, tick_ms);
                end
                sent += press_len + rel_len;
            end
            if ($urandom_range(0, 99) == 0)
                drain_results();
        end
    endtask

    // receiver: random stall before each result word, with stall-free stretches
    initial
    begin
        int stall;
        bit sink_burst;
        sink_burst = 1'b0;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 63) == 0)
                sink_burst = !sink_burst;
            stall = sink_burst ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            score_board.check_event(m_tdata[2:0]);
        end
    end

    initial
    begin
        score_board = new();
        src_burst = 1'b0;
        tick_ms   = '0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: tight timings so every event shows up within a few ticks
        set_timings(make_timings(16'd2, 16'd5, 16'd8, 16'd12, 16'd10), 1'b0);
        send_tick(1'b1, 32'd100);       // debounce starts
        send_tick(1'b1, 32'd101);       // still bouncing
        send_tick(1'b1, 32'd102);       // confirmed
        send_tick(1'b0, 32'd103);       // short
        send_tick(1'b1, 32'd104);
        send_tick(1'b1, 32'd106);
        send_tick(1'b0, 32'd108);       // double, inside the window
        send_tick(1'b1, 32'd110);
        send_tick(1'b1, 32'd112);
        send_tick(1'b1, 32'd117);       // long
        send_tick(1'b1, 32'd120);       // ota
        send_tick(1'b1, 32'd124);       // very long
        send_tick(1'b1, 32'd125);       // nothing more while held
        send_tick(1'b0, 32'd126);       // release after a hold: none
        send_tick(1'b1, 32'd130);
        send_tick(1'b1, 32'd132);
        send_tick(1'b1, 32'd150);       // all thresholds passed at once: only very long
        send_tick(1'b0, 32'd151);
        send_tick(1'b1, 32'd160);
        send_tick(1'b0, 32'd161);       // glitch dropped during debounce
        send_tick(1'b1, 32'hFFFF_FFFF); // time wraps during debounce
        send_tick(1'b1, 32'h0000_0000);
        send_tick(1'b1, 32'h0000_0001);
        send_tick(1'b0, 32'h0000_0002); // double again, still close to time zero
        tick_ms = 32'd200;
        drain_results();

        // reset timings written back explicitly
        set_timings(make_timings(RST_DEBOUNCE, RST_LONG_HOLD, RST_OTA_HOLD, RST_VLONG_HOLD,
                                 RST_DBL_WINDOW), 1'b1);
        run_presses(200, 300, 30);
        drain_results();

        // short timings, many events of every kind
        set_timings(make_timings(16'd3, 16'd10, 16'd20, 16'd30, 16'd15), 1'b1);
        run_presses(150, 4, 20);
        drain_results();
        run_presses(150, 4, 20);
        drain_results();

        // all zero: confirm on the next tick, very long straight after, no doubles
        set_timings(make_timings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0), 1'b0);
        run_presses(120, 3, 8);
        drain_results();

        // all at the top of the range
        set_timings(make_timings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1);
        run_presses(200, 12000, 20);
        drain_results();

        // thresholds out of order
        set_timings(make_timings(16'd1, 16'd30, 16'd20, 16'd10, 16'd20), 1'b1);
        run_presses(80, 4, 15);
        drain_results();
        set_timings(make_timings(16'd2, 16'd5, 16'd40, 16'd25, 16'hFFFF), 1'b0);
        run_presses(70, 5, 15);
        drain_results();

        // poll time running through the 32-bit wrap
        tick_ms = 32'hFFFF_FF00;
        set_timings(make_timings(16'd4, 16'd12, 16'd25, 16'd40, 16'd30), 1'b1);
        run_presses(130, 6, 15);
        drain_results();

        repeat (10) @(posedge clk);
        if (score_board.failures == 0 && score_board.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
design/bpc_pkg.sv
design/bpc_core.sv
design/button_press_classifier_unit.sv
design/bpc_checker.sv
tb/sv/bpc_event_checker_pkg.sv
tb/sv/button_press_classifier_unit_tb.sv
